// ----- sv/dsc_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, constants, tables and result types for the date and day-serial converter
package dsc_pkg;

    localparam int SERIAL_BITS = 24;
    localparam int STAGES      = 5;

    localparam int YEAR_IN_W     = 14;
    localparam int MONTH_IN_W    = 11;
    localparam int DAY_IN_W      = 23;
    localparam int SERIAL_IN_W   = 24;
    localparam int SERIAL_OUT_W  = 24;
    localparam int YEAR_OUT_W    = 15;
    localparam int MONTH_OUT_W   = 4;
    localparam int DAY_OUT_W     = 5;
    localparam int WEEKDAY_OUT_W = 3;

    localparam logic OP_TO_SERIAL = 1'b0;
    localparam logic OP_TO_DATE   = 1'b1;

    localparam int SHIFT_LIMIT = 61;
    localparam int EPOCH_DAY   = 693594;
    localparam int YEAR_MAX    = 9999;
    localparam int MONTHS      = 12;

    localparam int DAYS_400Y = 146097;
    localparam int DAYS_100Y = 36524;
    localparam int DAYS_4Y   = 1461;
    localparam int DAYS_1Y   = 365;

    // date to serial
    localparam int MO_W         = 12;
    localparam int MONTH_BIAS_Q = 86;
    localparam int MONTH_BIAS   = MONTH_BIAS_Q * MONTHS;
    localparam int MO_RECIP     = 2731;
    localparam int MO_SHIFT     = 15;
    localparam int MO_PROD_W    = 24;
    localparam int MO_Q_W       = 8;
    localparam int Y0_W         = 16;
    localparam int YP_W         = 14;
    localparam int C100_RECIP   = 5243;
    localparam int C100_SHIFT   = 19;
    localparam int C100_PROD_W  = 27;
    localparam int P100_W       = 7;
    localparam int DN_W         = 22;
    localparam int DAYS_W       = 25;
    localparam int RNG_LO       = (SERIAL_BITS - 1 < DAYS_W - 1) ? SERIAL_BITS - 1 : DAYS_W - 1;

    // serial to date
    localparam int JW       = SERIAL_BITS + 2;
    localparam int T_W      = SERIAL_BITS + 1;
    localparam int ND       = (T_W + 2) / 3;
    localparam int WSUM_W   = 7;
    localparam int WFOLD_W  = 4;
    localparam int K400     = SERIAL_BITS + 18;
    localparam logic [63:0] M400 = ((64'd1 << K400) + 64'd146096) / 64'd146097;
    localparam int P400_W   = 2 * SERIAL_BITS + 2;
    localparam int Q400_W   = SERIAL_BITS - 16;
    localparam int R_W      = 18;
    localparam int R1_W     = 16;
    localparam int K4       = 27;
    localparam logic [63:0] M4 = ((64'd1 << K4) + 64'd1460) / 64'd1461;
    localparam int P4_W     = 34;
    localparam int Q4_W     = 5;
    localparam int R2_W     = 11;
    localparam int R3_W     = 9;
    localparam int Y_W      = SERIAL_BITS - 7;
    localparam logic [63:0] WOFF =
        (((64'd1 << (SERIAL_BITS - 1)) + 64'd6) / 64'd7) * 64'd7 + 64'd7;

    typedef logic [STAGES-1:0] dsc_stage_en_t;

    typedef struct packed {
        logic [SERIAL_OUT_W-1:0] serial;
        logic                    error;
    } dsc_serial_res_t;

    typedef struct packed {
        logic [YEAR_OUT_W-1:0]    year;
        logic [MONTH_OUT_W-1:0]   month;
        logic [DAY_OUT_W-1:0]     day;
        logic [WEEKDAY_OUT_W-1:0] weekday;
        logic                     error;
    } dsc_date_res_t;

    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] v;
        case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/dsc_date_to_serial.sv -----
`timescale 1ns / 1ps
// Five-stage datapath turning a rolled year, month and day offset into a day serial
module dsc_date_to_serial
    import dsc_pkg::*;
(
    input  logic                          clk,
    input  dsc_stage_en_t                 stage_en,
    input  logic [YEAR_IN_W-1:0]          year_in,
    input  logic signed [MONTH_IN_W-1:0]  month_in,
    input  logic signed [DAY_IN_W-1:0]    day_in,
    output dsc_serial_res_t               res
);

    localparam logic signed [DAYS_W-1:0] LIMIT = DAYS_W'(SHIFT_LIMIT);

    // stage A
    logic [MO_W-1:0]              a_x_next;
    logic [MO_PROD_W-1:0]         a_prod;
    logic [MO_W-1:0]              a_x_reg;
    logic [MO_Q_W-1:0]            a_q_reg;
    logic [YEAR_IN_W-1:0]         a_year_reg;
    logic signed [DAY_IN_W-1:0]   a_day_reg;

    // stage B
    logic [Y0_W-1:0]              b_y;
    logic [YP_W-1:0]              b_p_next;
    logic [3:0]                   b_r_next;
    logic                         b_yerr_next;
    logic [YP_W-1:0]              b_p_reg;
    logic [3:0]                   b_r_reg;
    logic                         b_yerr_reg;
    logic signed [DAY_IN_W-1:0]   b_day_reg;

    // stage C
    logic [DN_W-1:0]              c_p365_next;
    logic [C100_PROD_W-1:0]       c_prod;
    logic [YP_W-1:0]              c_p_reg;
    logic [DN_W-1:0]              c_p365_reg;
    logic [P100_W-1:0]            c_p100_reg;
    logic [3:0]                   c_r_reg;
    logic                         c_yerr_reg;
    logic signed [DAY_IN_W-1:0]   c_day_reg;

    // stage D
    logic [P100_W-1:0]            d_pmod100;
    logic                         d_leap;
    logic [DN_W-1:0]              d_dn_next;
    logic [DN_W-1:0]              d_dn_reg;
    logic                         d_yerr_reg;
    logic signed [DAY_IN_W-1:0]   d_day_reg;

    // stage E
    logic [DAYS_W-1:0]            e_days_next;
    logic signed [DAYS_W-1:0]     e_days_reg;
    logic                         e_yerr_reg;
    logic signed [DAYS_W-1:0]     fin_days;
    logic                         rng_err;

    assign a_x_next = MO_W'(month_in) + MO_W'(MONTH_BIAS - 1);
    assign a_prod   = MO_PROD_W'(a_x_next) * MO_PROD_W'(MO_RECIP);

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            a_x_reg    <= a_x_next;
            a_q_reg    <= a_prod[MO_SHIFT +: MO_Q_W];
            a_year_reg <= year_in;
            a_day_reg  <= day_in;
        end
    end

    assign b_y         = Y0_W'(a_year_reg) + Y0_W'(a_q_reg) - Y0_W'(MONTH_BIAS_Q);
    assign b_yerr_next = b_y[Y0_W-1] || (b_y == '0) || (b_y > Y0_W'(YEAR_MAX));
    assign b_p_next    = YP_W'(b_y - Y0_W'(1));
    assign b_r_next    = 4'(a_x_reg - MO_W'(a_q_reg) * MO_W'(MONTHS));

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            b_p_reg    <= b_p_next;
            b_r_reg    <= b_r_next;
            b_yerr_reg <= b_yerr_next;
            b_day_reg  <= a_day_reg;
        end
    end

    assign c_p365_next = DN_W'(b_p_reg) * DN_W'(DAYS_1Y);
    assign c_prod      = C100_PROD_W'(b_p_reg) * C100_PROD_W'(C100_RECIP);

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            c_p_reg    <= b_p_reg;
            c_p365_reg <= c_p365_next;
            c_p100_reg <= c_prod[C100_SHIFT +: P100_W];
            c_r_reg    <= b_r_reg;
            c_yerr_reg <= b_yerr_reg;
            c_day_reg  <= b_day_reg;
        end
    end

    assign d_pmod100 = P100_W'(c_p_reg - YP_W'(c_p100_reg) * YP_W'(100));
    assign d_leap    = ((c_p_reg[1:0] == 2'd3) && (d_pmod100 != P100_W'(99)))
                    || ((d_pmod100 == P100_W'(99)) && (c_p100_reg[1:0] == 2'd3));
    assign d_dn_next = c_p365_reg + DN_W'(c_p_reg >> 2) - DN_W'(c_p100_reg)
                     + DN_W'(c_p100_reg >> 2) + DN_W'(month_start(c_r_reg))
                     + DN_W'((c_r_reg >= 4'd2) && d_leap) + DN_W'(1);

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            d_dn_reg   <= d_dn_next;
            d_yerr_reg <= c_yerr_reg;
            d_day_reg  <= c_day_reg;
        end
    end

    assign e_days_next = DAYS_W'(d_dn_reg) + DAYS_W'(d_day_reg) - DAYS_W'(EPOCH_DAY + 1);

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            e_days_reg <= e_days_next;
            e_yerr_reg <= d_yerr_reg;
        end
    end

    assign fin_days  = (e_days_reg < LIMIT) ? e_days_reg - LIMIT + LIMIT - DAYS_W'(1)
                                            : e_days_reg;
    assign rng_err   = !((&fin_days[DAYS_W-1:RNG_LO]) || (~|fin_days[DAYS_W-1:RNG_LO]));
    assign res.error  = e_yerr_reg || rng_err;
    assign res.serial = res.error ? '0 : SERIAL_OUT_W'(fin_days);

endmodule

// ----- sv/dsc_serial_to_date.sv -----
`timescale 1ns / 1ps
// Five-stage datapath turning a day serial into a Gregorian date and weekday
module dsc_serial_to_date
    import dsc_pkg::*;
(
    input  logic                           clk,
    input  dsc_stage_en_t                  stage_en,
    input  logic signed [SERIAL_IN_W-1:0]  serial_in,
    output dsc_date_res_t                  res
);

    localparam logic signed [SERIAL_BITS-1:0] S_LIMIT = SERIAL_BITS'(SHIFT_LIMIT);

    // stage A
    logic signed [SERIAL_BITS-1:0] a_s;
    logic                          a_lt;
    logic [JW-1:0]                 a_nx;
    logic [T_W-1:0]                a_t_next;
    logic [SERIAL_BITS-1:0]        a_n_reg;
    logic                          a_err_reg;
    logic [T_W-1:0]                a_t_reg;

    // stage B
    logic [P400_W-1:0]             b_prod;
    logic [ND*3-1:0]               b_t_pad;
    logic [WSUM_W-1:0]             b_wsum_next;
    logic [SERIAL_BITS-1:0]        b_n_reg;
    logic [Q400_W-1:0]             b_q400_reg;
    logic                          b_err_reg;
    logic [WSUM_W-1:0]             b_wsum_reg;

    // stage C
    logic [R_W-1:0]                c_r;
    logic [1:0]                    c_q100_next;
    logic [R1_W-1:0]               c_r1_next;
    logic [WFOLD_W-1:0]            c_wfold_next;
    logic [Q400_W-1:0]             c_q400_reg;
    logic [1:0]                    c_q100_reg;
    logic [R1_W-1:0]               c_r1_reg;
    logic                          c_err_reg;
    logic [WFOLD_W-1:0]            c_wfold_reg;

    // stage D
    logic [P4_W-1:0]               d_prod;
    logic [WEEKDAY_OUT_W-1:0]      d_wmod_next;
    logic [Q400_W-1:0]             d_q400_reg;
    logic [1:0]                    d_q100_reg;
    logic [Q4_W-1:0]               d_q4_reg;
    logic [R1_W-1:0]               d_r1_reg;
    logic                          d_err_reg;
    logic [WEEKDAY_OUT_W-1:0]      d_wmod_reg;

    // stage E
    logic [R2_W-1:0]               e_r2;
    logic [1:0]                    e_q1;
    logic [R3_W-1:0]               e_r3_next;
    logic [Y_W-1:0]                e_y_next;
    logic                          e_leap_next;
    logic [Y_W-1:0]                e_y_reg;
    logic [R3_W-1:0]               e_r3_reg;
    logic                          e_leap_reg;
    logic                          e_err_reg;
    logic [WEEKDAY_OUT_W-1:0]      e_wday_reg;

    // month search
    logic [R3_W-1:0]               st_cand;
    logic [R3_W-1:0]               st_sel;
    logic [MONTH_OUT_W-1:0]        mon;

    assign a_s      = SERIAL_BITS'(serial_in);
    assign a_lt     = a_s < S_LIMIT;
    assign a_nx     = JW'(a_s) + JW'(a_lt) + JW'(EPOCH_DAY - 1);
    assign a_t_next = T_W'(a_s) - (a_lt ? T_W'(1) : T_W'(2)) + T_W'(WOFF);

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            a_n_reg   <= a_nx[SERIAL_BITS-1:0];
            a_err_reg <= a_nx[JW-1];
            a_t_reg   <= a_t_next;
        end
    end

    assign b_prod  = P400_W'(a_n_reg) * P400_W'(M400);
    assign b_t_pad = (ND*3)'(a_t_reg);

    // octal digit sum, since eight is one modulo seven
    always_comb
    begin
        b_wsum_next = '0;
        for (int i = 0; i < ND; i++)
        begin
            b_wsum_next = b_wsum_next + WSUM_W'(b_t_pad[3*i +: 3]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            b_n_reg    <= a_n_reg;
            b_q400_reg <= b_prod[K400 +: Q400_W];
            b_err_reg  <= a_err_reg;
            b_wsum_reg <= b_wsum_next;
        end
    end

    assign c_r = R_W'(b_n_reg - SERIAL_BITS'(b_q400_reg) * SERIAL_BITS'(DAYS_400Y));

    always_comb
    begin
        if (c_r >= R_W'(3 * DAYS_100Y))
        begin
            c_q100_next = 2'd3;
        end
        else if (c_r >= R_W'(2 * DAYS_100Y))
        begin
            c_q100_next = 2'd2;
        end
        else if (c_r >= R_W'(DAYS_100Y))
        begin
            c_q100_next = 2'd1;
        end
        else
        begin
            c_q100_next = 2'd0;
        end
    end

    assign c_r1_next    = R1_W'(c_r - R_W'(c_q100_next) * R_W'(DAYS_100Y));
    assign c_wfold_next = WFOLD_W'(b_wsum_reg[6]) + WFOLD_W'(b_wsum_reg[5:3])
                        + WFOLD_W'(b_wsum_reg[2:0]);

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            c_q400_reg  <= b_q400_reg;
            c_q100_reg  <= c_q100_next;
            c_r1_reg    <= c_r1_next;
            c_err_reg   <= b_err_reg;
            c_wfold_reg <= c_wfold_next;
        end
    end

    assign d_prod = P4_W'(c_r1_reg) * P4_W'(M4);

    always_comb
    begin
        if (c_wfold_reg >= WFOLD_W'(14))
        begin
            d_wmod_next = WEEKDAY_OUT_W'(c_wfold_reg - WFOLD_W'(14));
        end
        else if (c_wfold_reg >= WFOLD_W'(7))
        begin
            d_wmod_next = WEEKDAY_OUT_W'(c_wfold_reg - WFOLD_W'(7));
        end
        else
        begin
            d_wmod_next = WEEKDAY_OUT_W'(c_wfold_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            d_q400_reg <= c_q400_reg;
            d_q100_reg <= c_q100_reg;
            d_q4_reg   <= d_prod[K4 +: Q4_W];
            d_r1_reg   <= c_r1_reg;
            d_err_reg  <= c_err_reg;
            d_wmod_reg <= d_wmod_next;
        end
    end

    assign e_r2 = R2_W'(d_r1_reg - R1_W'(d_q4_reg) * R1_W'(DAYS_4Y));

    always_comb
    begin
        if (e_r2 >= R2_W'(3 * DAYS_1Y))
        begin
            e_q1 = 2'd3;
        end
        else if (e_r2 >= R2_W'(2 * DAYS_1Y))
        begin
            e_q1 = 2'd2;
        end
        else if (e_r2 >= R2_W'(DAYS_1Y))
        begin
            e_q1 = 2'd1;
        end
        else
        begin
            e_q1 = 2'd0;
        end
    end

    assign e_r3_next   = R3_W'(e_r2 - R2_W'(e_q1) * R2_W'(DAYS_1Y));
    assign e_y_next    = Y_W'(d_q400_reg) * Y_W'(400) + Y_W'(d_q100_reg) * Y_W'(100)
                       + Y_W'(d_q4_reg) * Y_W'(4) + Y_W'(e_q1) + Y_W'(1);
    // fourth year of a cycle; century years leap only at the end of the 400-year cycle
    assign e_leap_next = (e_q1 == 2'd3) && ((d_q4_reg != Q4_W'(24)) || (d_q100_reg == 2'd3));

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            e_y_reg    <= e_y_next;
            e_r3_reg   <= e_r3_next;
            e_leap_reg <= e_leap_next;
            e_err_reg  <= d_err_reg;
            e_wday_reg <= d_wmod_reg + WEEKDAY_OUT_W'(1);
        end
    end

    always_comb
    begin
        mon    = MONTH_OUT_W'(1);
        st_sel = '0;
        for (int i = 0; i < MONTHS; i++)
        begin
            st_cand = R3_W'(month_start(4'(i))) + R3_W'((i >= 2) && e_leap_reg);
            if (e_r3_reg >= st_cand)
            begin
                mon    = MONTH_OUT_W'(i + 1);
                st_sel = st_cand;
            end
        end
    end

    assign res.error   = e_err_reg;
    assign res.year    = e_err_reg ? '0 : YEAR_OUT_W'(e_y_reg);
    assign res.month   = e_err_reg ? '0 : mon;
    assign res.day     = e_err_reg ? '0 : DAY_OUT_W'(e_r3_reg - st_sel + R3_W'(1));
    assign res.weekday = e_err_reg ? '0 : e_wday_reg;

endmodule

// ----- sv/date_serial_converter_unit.sv -----
`timescale 1ns / 1ps
// Top level of the date and day-serial converter: stage control, mode select, output register
// Five datapath stages, then one output stage, lie between an input transfer and out_valid.
// Throughput: one item per cycle; each stage holds only while the stage after it is full
// and stalled, so a waiting result does not block input while any stage is empty.
// Reset: rst_n clears all stage valid bits and out_valid; datapath registers are not reset.
// Both conversions run side by side; the item's operation bit picks the result at the output.
module date_serial_converter_unit
    import dsc_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           operation,
    input  logic [YEAR_IN_W-1:0]           year_in,
    input  logic signed [MONTH_IN_W-1:0]   month_in,
    input  logic signed [DAY_IN_W-1:0]     day_in,
    input  logic signed [SERIAL_IN_W-1:0]  serial_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SERIAL_OUT_W-1:0] serial_out,
    output logic [YEAR_OUT_W-1:0]          year_out,
    output logic [MONTH_OUT_W-1:0]         month_out,
    output logic [DAY_OUT_W-1:0]           day_out,
    output logic [WEEKDAY_OUT_W-1:0]       weekday_out,
    output logic                           error
);

    dsc_stage_en_t            stage_en;
    logic                     out_en;
    logic [STAGES-1:0]        vld_reg;
    logic [STAGES-1:0]        vld_next;
    logic [STAGES-1:0]        op_reg;
    logic                     out_valid_reg;
    logic [SERIAL_OUT_W-1:0]  serial_reg;
    logic [YEAR_OUT_W-1:0]    year_reg;
    logic [MONTH_OUT_W-1:0]   month_reg;
    logic [DAY_OUT_W-1:0]     day_reg;
    logic [WEEKDAY_OUT_W-1:0] weekday_reg;
    logic                     error_reg;
    dsc_serial_res_t          sres;
    dsc_date_res_t            dres;

    dsc_date_to_serial u_to_serial (
        .clk      (clk),
        .stage_en (stage_en),
        .year_in  (year_in),
        .month_in (month_in),
        .day_in   (day_in),
        .res      (sres)
    );

    dsc_serial_to_date u_to_date (
        .clk       (clk),
        .stage_en  (stage_en),
        .serial_in (serial_in),
        .res       (dres)
    );

    // advance a stage when it is empty or the next one advances
    always_comb
    begin
        out_en = !out_valid_reg || out_ready;
        stage_en[STAGES-1] = !vld_reg[STAGES-1] || out_en;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            stage_en[i] = !vld_reg[i] || stage_en[i+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (stage_en[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int i = 1; i < STAGES; i++)
        begin
            if (stage_en[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (out_en)
            begin
                out_valid_reg <= vld_reg[STAGES-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            op_reg[0] <= operation;
        end
        for (int i = 1; i < STAGES; i++)
        begin
            if (stage_en[i])
            begin
                op_reg[i] <= op_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            if (op_reg[STAGES-1] == OP_TO_SERIAL)
            begin
                serial_reg  <= sres.serial;
                year_reg    <= '0;
                month_reg   <= '0;
                day_reg     <= '0;
                weekday_reg <= '0;
                error_reg   <= sres.error;
            end
            else
            begin
                serial_reg  <= '0;
                year_reg    <= dres.year;
                month_reg   <= dres.month;
                day_reg     <= dres.day;
                weekday_reg <= dres.weekday;
                error_reg   <= dres.error;
            end
        end
    end

    assign in_ready    = stage_en[0];
    assign out_valid   = out_valid_reg;
    assign serial_out  = serial_reg;
    assign year_out    = year_reg;
    assign month_out   = month_reg;
    assign day_out     = day_reg;
    assign weekday_out = weekday_reg;
    assign error       = error_reg;

endmodule

// ----- sim/tb_date_serial_converter_unit.sv -----
`timescale 1ns / 1ps
// Testbench for date_serial_converter_unit: directed table and random conversions
module tb_date_serial_converter_unit;
    import dsc_pkg::*;

    localparam int     WEEK_DAYS     = 7;
    localparam int     PHASE_ITEMS   = 470;
    localparam int     DRAIN_CYCLES  = 20;
    localparam int     STALL_LIMIT   = 5000;
    localparam int     REPORT_LIMIT  = 10;
    localparam longint SERIAL_MAX    = (longint'(1) << (SERIAL_BITS - 1)) - 1;
    localparam longint SERIAL_MIN    = -SERIAL_MAX - 1;
    localparam int     LAST_SERIAL   = 2958465;
    localparam logic [11:0][8:0] DAYS_BEFORE_MONTH = {
        9'd334, 9'd304, 9'd273, 9'd243, 9'd212, 9'd181,
        9'd151, 9'd120, 9'd90,  9'd59,  9'd31,  9'd0
    };

    typedef struct packed {
        logic                   operation;
        logic [YEAR_IN_W-1:0]   year;
        logic [MONTH_IN_W-1:0]  month;
        logic [DAY_IN_W-1:0]    day;
        logic [SERIAL_IN_W-1:0] serial;
    } conv_req_t;

    typedef struct packed {
        logic [SERIAL_OUT_W-1:0]  serial;
        logic [YEAR_OUT_W-1:0]    year;
        logic [MONTH_OUT_W-1:0]   month;
        logic [DAY_OUT_W-1:0]     day;
        logic [WEEKDAY_OUT_W-1:0] weekday;
        logic                     error;
    } conv_res_t;

    typedef struct packed {
        conv_req_t req;
        logic      pinned;
        conv_res_t res;
    } stim_row_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    logic                           operation = OP_TO_SERIAL;
    logic [YEAR_IN_W-1:0]           year_in   = '0;
    logic signed [MONTH_IN_W-1:0]   month_in  = '0;
    logic signed [DAY_IN_W-1:0]     day_in    = '0;
    logic signed [SERIAL_IN_W-1:0]  serial_in = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic signed [SERIAL_OUT_W-1:0] serial_out;
    logic [YEAR_OUT_W-1:0]          year_out;
    logic [MONTH_OUT_W-1:0]         month_out;
    logic [DAY_OUT_W-1:0]           day_out;
    logic [WEEKDAY_OUT_W-1:0]       weekday_out;
    logic                           error;

    stim_row_t   stim_table[$];
    stim_row_t   sent_rows[$];
    conv_res_t   pending_results[$];
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned failures       = 0;
    int unsigned n_to_serial    = 0;
    int unsigned n_to_date      = 0;
    int unsigned n_errors       = 0;

    date_serial_converter_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .year_in     (year_in),
        .month_in    (month_in),
        .day_in      (day_in),
        .serial_in   (serial_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .serial_out  (serial_out),
        .year_out    (year_out),
        .month_out   (month_out),
        .day_out     (day_out),
        .weekday_out (weekday_out),
        .error       (error)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic bit leap_year(input longint yr);
        return (yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0;
    endfunction

    function automatic conv_res_t date_serial_convert(input conv_req_t rq);
        conv_res_t res;
        longint    yr, mo, q, r, days, jd, n, s, w, dom;
        longint    q400, q100, q4, q1;
        int        mon, st, lp;
        res = '0;
        if (rq.operation == OP_TO_SERIAL)
        begin
            yr = longint'(rq.year);
            mo = longint'($signed(rq.month)) - 1;
            q  = mo / MONTHS;
            r  = mo % MONTHS;
            if (r < 0)
            begin
                r += MONTHS;
                q -= 1;
            end
            yr += q;
            if (yr < 1 || yr > YEAR_MAX)
                res.error = 1'b1;
            else
            begin
                n    = yr - 1;
                st   = int'(DAYS_BEFORE_MONTH[r]);
                days = n * 365 + n / 4 - n / 100 + n / 400 + st + 1;
                if (r >= 2 && leap_year(yr))
                    days += 1;
                days = days - EPOCH_DAY + (longint'($signed(rq.day)) - 1);
                if (days < SHIFT_LIMIT)
                    days -= 1;
                if (days < SERIAL_MIN || days > SERIAL_MAX)
                    res.error = 1'b1;
                else
                    res.serial = days[SERIAL_OUT_W-1:0];
            end
        end
        else
        begin
            s    = longint'($signed(rq.serial));
            days = (s < SHIFT_LIMIT) ? s + 1 : s;
            jd   = EPOCH_DAY + days;
            if (jd < 1)
                res.error = 1'b1;
            else
            begin
                n    = jd - 1;
                q400 = n / DAYS_400Y;
                r    = n % DAYS_400Y;
                q100 = r / DAYS_100Y;
                if (q100 > 3)
                    q100 = 3;
                r   -= q100 * DAYS_100Y;
                q4   = r / DAYS_4Y;
                r    = r % DAYS_4Y;
                q1   = r / DAYS_1Y;
                if (q1 > 3)
                    q1 = 3;
                r   -= q1 * DAYS_1Y;
                yr   = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
                lp   = leap_year(yr) ? 1 : 0;
                mon  = MONTHS;
                st   = int'(DAYS_BEFORE_MONTH[MONTHS - 1]) + lp;
                while (r < st && mon > 1)
                begin
                    mon--;
                    st = int'(DAYS_BEFORE_MONTH[mon - 1]);
                    if (mon > 2)
                        st += lp;
                end
                dom = r - st + 1;
                w   = (s >= SHIFT_LIMIT) ? s - 1 : s;
                w   = ((w - 1) % WEEK_DAYS + WEEK_DAYS) % WEEK_DAYS + 1;
                res.year    = yr[YEAR_OUT_W-1:0];
                res.month   = mon[MONTH_OUT_W-1:0];
                res.day     = dom[DAY_OUT_W-1:0];
                res.weekday = w[WEEKDAY_OUT_W-1:0];
            end
        end
        return res;
    endfunction

    function automatic conv_res_t serial_result(input int ser);
        conv_res_t res;
        res        = '0;
        res.serial = ser[SERIAL_OUT_W-1:0];
        return res;
    endfunction

    function automatic conv_res_t date_result(input int yr, input int mon, input int dy,
                                              input int wd);
        conv_res_t res;
        res         = '0;
        res.year    = yr[YEAR_OUT_W-1:0];
        res.month   = mon[MONTH_OUT_W-1:0];
        res.day     = dy[DAY_OUT_W-1:0];
        res.weekday = wd[WEEKDAY_OUT_W-1:0];
        return res;
    endfunction

    function automatic conv_res_t error_result();
        conv_res_t res;
        res       = '0;
        res.error = 1'b1;
        return res;
    endfunction

    function automatic void add_row(input logic op, input int yr, input int mon, input int dy,
                                    input int ser, input logic pinned, input conv_res_t res);
        stim_row_t row;
        row.req.operation = op;
        row.req.year      = yr[YEAR_IN_W-1:0];
        row.req.month     = mon[MONTH_IN_W-1:0];
        row.req.day       = dy[DAY_IN_W-1:0];
        row.req.serial    = ser[SERIAL_IN_W-1:0];
        row.pinned        = pinned;
        row.res           = res;
        stim_table.push_back(row);
    endfunction

    function automatic stim_row_t random_row();
        stim_row_t   row;
        int unsigned pick;
        row.req.operation = $urandom_range(1) ? OP_TO_DATE : OP_TO_SERIAL;
        row.req.year      = YEAR_IN_W'($urandom);
        row.req.month     = MONTH_IN_W'($urandom);
        row.req.day       = DAY_IN_W'($urandom);
        row.req.serial    = SERIAL_IN_W'($urandom);
        row.pinned        = 1'b0;
        row.res           = '0;
        pick              = $urandom_range(99);
        if (row.req.operation == OP_TO_SERIAL)
        begin
            if (pick < 90)
                row.req.year = YEAR_IN_W'($urandom_range(YEAR_MAX, 1));
            if (pick < 55)
            begin
                row.req.month = MONTH_IN_W'($urandom_range(MONTHS, 1));
                row.req.day   = DAY_IN_W'($urandom_range(32, 0));
            end
            else if (pick < 70)
                row.req.month = MONTH_IN_W'($urandom_range(MONTHS, 1));
        end
        else
        begin
            if (pick < 55)
                row.req.serial = SERIAL_IN_W'($urandom_range(LAST_SERIAL, 0));
            else if (pick < 70)
                row.req.serial = SERIAL_IN_W'($urandom_range(120, 0));
            else if (pick < 80)
                row.req.serial =
                    SERIAL_IN_W'(-$urandom_range(EPOCH_DAY + 100, EPOCH_DAY - 100));
        end
        return row;
    endfunction

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function automatic void check_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want)
            note_failure($sformatf("%s expected %0d, got %0d", name, want, got));
    endfunction

    task automatic drive_request(input stim_row_t row);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        sent_rows.push_back(row);
        in_valid  <= 1'b1;
        operation <= row.req.operation;
        year_in   <= row.req.year;
        month_in  <= row.req.month;
        day_in    <= row.req.day;
        serial_in <= row.req.serial;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : scoreboard
        conv_req_t rq;
        conv_res_t got, want;
        stim_row_t row;
        if (rst_n && in_valid && in_ready)
        begin
            rq.operation = operation;
            rq.year      = year_in;
            rq.month     = month_in;
            rq.day       = day_in;
            rq.serial    = serial_in;
            row          = sent_rows.pop_front();
            pending_results.push_back(row.pinned ? row.res : date_serial_convert(rq));
            if (operation == OP_TO_SERIAL)
                n_to_serial++;
            else
                n_to_date++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            got.serial  = serial_out;
            got.year    = year_out;
            got.month   = month_out;
            got.day     = day_out;
            got.weekday = weekday_out;
            got.error   = error;
            if (pending_results.size() == 0)
                note_failure("result transfer with no conversion outstanding");
            else
            begin
                want = pending_results.pop_front();
                if (want.error)
                    n_errors++;
                check_field("serial_out", 32'($signed(want.serial)),
                            32'($signed(got.serial)));
                check_field("year_out", 32'(want.year), 32'(got.year));
                check_field("month_out", 32'(want.month), 32'(got.month));
                check_field("day_out", 32'(want.day), 32'(got.day));
                check_field("weekday_out", 32'(want.weekday), 32'(got.weekday));
                check_field("error", 32'(want.error), 32'(got.error));
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : stimulus
        int phase;
        int k;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(OP_TO_SERIAL, 1900, 1, 1, 0, 1'b1, serial_result(1));
        add_row(OP_TO_SERIAL, 1899, 12, 31, 0, 1'b1, serial_result(0));
        add_row(OP_TO_SERIAL, 1900, 2, 28, 0, 1'b1, serial_result(59));
        add_row(OP_TO_SERIAL, 1900, 2, 29, 0, 1'b0, '0);
        add_row(OP_TO_SERIAL, 1900, 3, 1, 0, 1'b0, '0);
        add_row(OP_TO_SERIAL, 0, 1, 1, 0, 1'b1, error_result());
        add_row(OP_TO_SERIAL, 16383, 12, 31, 0, 1'b1, error_result());
        add_row(OP_TO_SERIAL, 9999, 13, 1, 0, 1'b1, error_result());
        add_row(OP_TO_SERIAL, 1, 0, 1, 0, 1'b1, error_result());
        add_row(OP_TO_SERIAL, 1, 1, 1, 0, 1'b1, serial_result(-693594));
        add_row(OP_TO_SERIAL, 9999, 12, 31, 0, 1'b1, serial_result(LAST_SERIAL));
        add_row(OP_TO_SERIAL, 1900, 1, 4194303, 0, 1'b0, '0);
        add_row(OP_TO_SERIAL, 2000, 1, -4194304, 0, 1'b0, '0);
        add_row(OP_TO_SERIAL, 5000, 1023, 15, 0, 1'b0, '0);
        add_row(OP_TO_SERIAL, 9999, -1024, 1, 0, 1'b0, '0);
        add_row(OP_TO_SERIAL, 2000, 2, 29, 0, 1'b0, '0);
        add_row(OP_TO_DATE, 0, 0, 0, 1, 1'b1, date_result(1900, 1, 1, 1));
        add_row(OP_TO_DATE, 0, 0, 0, 0, 1'b1, date_result(1899, 12, 31, 7));
        add_row(OP_TO_DATE, 0, 0, 0, 59, 1'b0, '0);
        add_row(OP_TO_DATE, 0, 0, 0, 60, 1'b0, '0);
        add_row(OP_TO_DATE, 0, 0, 0, 61, 1'b0, '0);
        add_row(OP_TO_DATE, 0, 0, 0, -693594, 1'b1, date_result(1, 1, 1, 1));
        add_row(OP_TO_DATE, 0, 0, 0, -693595, 1'b1, error_result());
        add_row(OP_TO_DATE, 0, 0, 0, -8388608, 1'b1, error_result());
        add_row(OP_TO_DATE, 0, 0, 0, 8388607, 1'b0, '0);

        foreach (stim_table[i])
            drive_request(stim_table[i]);

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            for (k = 0; k < PHASE_ITEMS; k++)
                drive_request(random_row());
        end
        in_valid <= 1'b0;

        while (sent_rows.size() != 0 || pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d date-to-serial and %0d serial-to-date transfers,",
                 n_to_serial, n_to_date);
        $display("%0d of them flagged as errors, over four flow-control phases.", n_errors);
        if (failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
